@@ rtl/gpshd_pkg.sv @@
package gpshd_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// datapath word widths
	localparam int CW = 36;
	localparam int ZW = 34;
	localparam int PW = 2 * CW;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [CW-1:0] DEG7_TO_BAM = 36'sd1281023894;
	localparam logic signed [CW-1:0] HEAD_SCALE  = 36'sd36000;

	localparam int CFG_IW = 8;
	localparam int CFG_DW = 32;
	localparam logic [CFG_IW-1:0] REG_MIN_SPEED = 8'd0;
	localparam logic [CFG_IW-1:0] REG_MIN_MOVE  = 8'd1;

	localparam logic [16:0] MIN_SPEED_RST = 17'd200;
	localparam logic [19:0] MIN_MOVE_RST  = 20'd50;

	typedef enum logic [3:0] {
		MS_LAT1, MS_LON1, MS_LAT2, MS_LON2, MS_Y, MS_T, MS_P, MS_Q, MS_H
	} mul_sel_t;

	typedef enum logic [1:0] {RS_LAT1, RS_LAT2, RS_DLON} rot_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     dlon;
		logic     rot_init;
		rot_sel_t rot_sel;
		logic     rot_wr;
		logic     vec_init;
		logic     step;
		logic     out_wr;
		logic     out_rel;
	} dp_cmd_t;

	typedef struct packed {
		logic go;
		logic cordic_last;
		logic out_full;
	} dp_stat_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/gpshd_ifs.sv @@
interface fix_if;
	logic               valid;
	logic               ready;
	logic               fix_valid;
	logic signed [30:0] fix_lat;
	logic signed [31:0] fix_lon;
	logic        [16:0] fix_speed;
	modport source (output valid, fix_valid, fix_lat, fix_lon, fix_speed, input ready);
	modport sink (input valid, fix_valid, fix_lat, fix_lon, fix_speed, output ready);
endinterface

interface head_if;
	logic        valid;
	logic        ready;
	logic [15:0] heading_cdeg;
	logic        heading_reliable;
	modport source (output valid, heading_cdeg, heading_reliable, input ready);
	modport sink (input valid, heading_cdeg, heading_reliable, output ready);
endinterface

interface cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/gpshd_dp.sv @@
module gpshd_dp #(
	parameter int CORDIC_STEPS = gpshd_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	cfg_if.sink                cfg,
	head_if.source             head,
	input  logic               in_fix_valid,
	input  logic signed [30:0] in_lat,
	input  logic signed [31:0] in_lon,
	input  logic        [16:0] in_speed,
	input  gpshd_pkg::dp_cmd_t cmd,
	output gpshd_pkg::dp_stat_t stat
);
	import gpshd_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	logic [16:0] min_speed_q;
	logic [19:0] min_move_q;

	logic signed [30:0] lat1_q, cur_lat_q;
	logic signed [31:0] lon1_q, cur_lon_q;
	logic               prev_valid_q;
	logic               gate_q;
	logic [31:0]        adl_q;
	logic [32:0]        adn_q;

	logic [31:0] bam_lat1_q, bam_lon1_q, bam_lat2_q, bam_lon2_q, dlon_q;
	logic signed [CW-1:0] s1_q, c1_q, s2_q, c2_q, sd_q, cd_q;
	logic signed [CW-1:0] y_q, t_q, p_q, q_q;
	logic [15:0] held_q;

	logic signed [CW-1:0] op_a, op_b;
	logic                 op_neg;
	logic signed [PW-1:0] prod_s1;
	mul_sel_t             msel_s1;
	logic                 mneg_s1;
	logic                 mval_s1;
	logic [61:0]          rsum;
	logic [31:0]          bam_mag, bam_val;
	logic signed [CW-1:0] shv;

	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [IW-1:0]        ci_q;
	logic                 flip_q, vmode_q;
	rot_sel_t             rdest_q;
	logic [31:0]          rot_a, rot_t, rot_a2;
	logic signed [CW-1:0] sx, sy, xv;
	logic signed [ZW-1:0] at;

	logic        out_valid_q;
	logic [15:0] out_head_q;
	logic        out_rel_q;

	logic signed [32:0] dl_w;
	logic signed [33:0] dn_w;
	logic [33:0]        move_w;

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= MIN_SPEED_RST;
			min_move_q  <= MIN_MOVE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_SPEED: min_speed_q <= cfg.data[16:0];
				REG_MIN_MOVE:  min_move_q  <= cfg.data[19:0];
				default: ;
			endcase
		end
	end

	// fix capture and gating
	assign dl_w = {{2{in_lat[30]}}, in_lat} - {{2{cur_lat_q[30]}}, cur_lat_q};
	assign dn_w = {{2{in_lon[31]}}, in_lon} - {{2{cur_lon_q[31]}}, cur_lon_q};
	assign move_w = {2'b0, adl_q} + {1'b0, adn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_lat_q    <= '0;
			cur_lon_q    <= '0;
			prev_valid_q <= 1'b0;
			gate_q       <= 1'b0;
		end else if (cmd.load) begin
			cur_lat_q    <= in_lat;
			cur_lon_q    <= in_lon;
			prev_valid_q <= in_fix_valid;
			gate_q       <= in_fix_valid & prev_valid_q & (in_speed >= min_speed_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lat1_q <= cur_lat_q;
			lon1_q <= cur_lon_q;
			adl_q  <= dl_w[32] ? 32'(-dl_w) : dl_w[31:0];
			adn_q  <= dn_w[33] ? 33'(-dn_w) : dn_w[32:0];
		end
	end

	// shared multiplier
	always_comb begin
		op_a   = '0;
		op_b   = DEG7_TO_BAM;
		op_neg = 1'b0;
		case (cmd.mul_sel)
			MS_LAT1: begin
				op_neg = lat1_q[30];
				op_a   = {{(CW-31){lat1_q[30]}}, lat1_q};
			end
			MS_LON1: begin
				op_neg = lon1_q[31];
				op_a   = {{(CW-32){lon1_q[31]}}, lon1_q};
			end
			MS_LAT2: begin
				op_neg = cur_lat_q[30];
				op_a   = {{(CW-31){cur_lat_q[30]}}, cur_lat_q};
			end
			MS_LON2: begin
				op_neg = cur_lon_q[31];
				op_a   = {{(CW-32){cur_lon_q[31]}}, cur_lon_q};
			end
			MS_Y: begin
				op_a = sd_q;
				op_b = c2_q;
			end
			MS_T: begin
				op_a = s1_q;
				op_b = c2_q;
			end
			MS_P: begin
				op_a = c1_q;
				op_b = s2_q;
			end
			MS_Q: begin
				op_a = t_q;
				op_b = cd_q;
			end
			MS_H: begin
				op_a = {{(CW-32){1'b0}}, cz_q[31:0]};
				op_b = HEAD_SCALE;
			end
			default: ;
		endcase
		if (op_neg)
			op_a = -op_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mval_s1 <= 1'b0;
		else
			mval_s1 <= cmd.mul_go;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= op_a * op_b;
			msel_s1 <= cmd.mul_sel;
			mneg_s1 <= op_neg;
		end
	end

	assign rsum    = prod_s1[61:0] + 62'h2000_0000;
	assign bam_mag = rsum[61:30];
	assign bam_val = mneg_s1 ? (32'd0 - bam_mag) : bam_mag;
	assign shv     = prod_s1[CW+29:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (mval_s1 && msel_s1 == MS_H)
			held_q <= prod_s1[47:32];
	end

	always_ff @(posedge clk) begin
		if (mval_s1) begin
			case (msel_s1)
				MS_LAT1: bam_lat1_q <= bam_val;
				MS_LON1: bam_lon1_q <= bam_val;
				MS_LAT2: bam_lat2_q <= bam_val;
				MS_LON2: bam_lon2_q <= bam_val;
				MS_Y:    y_q <= shv;
				MS_T:    t_q <= shv;
				MS_P:    p_q <= shv;
				MS_Q:    q_q <= shv;
				default: ;
			endcase
		end
		if (cmd.dlon)
			dlon_q <= bam_lon2_q - bam_lon1_q;
	end

	// shared cordic
	always_comb begin
		case (cmd.rot_sel)
			RS_LAT1: rot_a = bam_lat1_q;
			RS_LAT2: rot_a = bam_lat2_q;
			default: rot_a = dlon_q;
		endcase
		rot_t  = rot_a + 32'h4000_0000;
		rot_a2 = rot_t[31] ? (rot_a ^ 32'h8000_0000) : rot_a;
		sx     = cx_q >>> ci_q;
		sy     = cy_q >>> ci_q;
		at     = {{(ZW-32){1'b0}}, atan_lut(5'(ci_q))};
		xv     = p_q - q_q;
	end

	assign stat.cordic_last = (ci_q == IW'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.rot_init) begin
			cx_q    <= CORDIC_GAIN;
			cy_q    <= '0;
			cz_q    <= {{(ZW-32){rot_a2[31]}}, rot_a2};
			ci_q    <= '0;
			flip_q  <= rot_t[31];
			vmode_q <= 1'b0;
			rdest_q <= cmd.rot_sel;
		end else if (cmd.vec_init) begin
			ci_q    <= '0;
			vmode_q <= 1'b1;
			if (xv[CW-1]) begin
				cx_q <= -xv;
				cy_q <= -y_q;
				cz_q <= ZW'(34'h0_8000_0000);
			end else begin
				cx_q <= xv;
				cy_q <= y_q;
				cz_q <= '0;
			end
		end else if (cmd.step) begin
			ci_q <= ci_q + 1'b1;
			if (!vmode_q) begin
				if (!cz_q[ZW-1]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + at;
				end
			end else if (!cy_q[CW-1] && (cy_q != '0)) begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + at;
			end else if (cy_q[CW-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rot_wr) begin
			case (rdest_q)
				RS_LAT1: begin
					s1_q <= flip_q ? -cy_q : cy_q;
					c1_q <= flip_q ? -cx_q : cx_q;
				end
				RS_LAT2: begin
					s2_q <= flip_q ? -cy_q : cy_q;
					c2_q <= flip_q ? -cx_q : cx_q;
				end
				default: begin
					sd_q <= flip_q ? -cy_q : cy_q;
					cd_q <= flip_q ? -cx_q : cx_q;
				end
			endcase
		end
	end

	assign stat.go = gate_q & (move_w >= {14'd0, min_move_q});

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_wr)
			out_valid_q <= 1'b1;
		else if (head.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			out_head_q <= held_q;
			out_rel_q  <= cmd.out_rel;
		end
	end

	assign stat.out_full         = out_valid_q;
	assign head.valid            = out_valid_q;
	assign head.heading_cdeg     = out_head_q;
	assign head.heading_reliable = out_rel_q;

endmodule

@@ rtl/gpshd_ctrl.sv @@
module gpshd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output gpshd_pkg::dp_cmd_t  cmd,
	input  gpshd_pkg::dp_stat_t stat
);
	import gpshd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_BAM, S_BWAIT, S_DLON, S_RINIT, S_RRUN, S_RWB,
		S_PROD, S_QMUL, S_QWAIT, S_VINIT, S_VRUN, S_HMUL, S_HWAIT, S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	rot_sel_t   rsel_q;
	logic       rel_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MS_LAT1;
		cmd.rot_sel = rsel_q;
		cmd.out_rel = rel_q;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_BAM: begin
				cmd.mul_go = 1'b1;
				unique case (k_q)
					2'd0: cmd.mul_sel = MS_LAT1;
					2'd1: cmd.mul_sel = MS_LON1;
					2'd2: cmd.mul_sel = MS_LAT2;
					default: cmd.mul_sel = MS_LON2;
				endcase
			end
			S_DLON:  cmd.dlon = 1'b1;
			S_RINIT: cmd.rot_init = 1'b1;
			S_RRUN:  cmd.step = 1'b1;
			S_RWB:   cmd.rot_wr = 1'b1;
			S_PROD: begin
				cmd.mul_go = 1'b1;
				unique case (k_q)
					2'd0: cmd.mul_sel = MS_Y;
					2'd1: cmd.mul_sel = MS_T;
					default: cmd.mul_sel = MS_P;
				endcase
			end
			S_QMUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_Q;
			end
			S_VINIT: cmd.vec_init = 1'b1;
			S_VRUN:  cmd.step = 1'b1;
			S_HMUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_H;
			end
			S_FIN:   cmd.out_wr = !stat.out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			rsel_q  <= RS_LAT1;
			rel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					rel_q <= stat.go;
					k_q   <= '0;
					state_q <= stat.go ? S_BAM : S_FIN;
				end
				S_BAM: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) state_q <= S_BWAIT;
				end
				S_BWAIT: state_q <= S_DLON;
				S_DLON: begin
					rsel_q  <= RS_LAT1;
					state_q <= S_RINIT;
				end
				S_RINIT: state_q <= S_RRUN;
				S_RRUN: if (stat.cordic_last) state_q <= S_RWB;
				S_RWB: begin
					unique case (rsel_q)
						RS_LAT1: begin
							rsel_q  <= RS_LAT2;
							state_q <= S_RINIT;
						end
						RS_LAT2: begin
							rsel_q  <= RS_DLON;
							state_q <= S_RINIT;
						end
						default: begin
							k_q     <= '0;
							state_q <= S_PROD;
						end
					endcase
				end
				S_PROD: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd2) state_q <= S_QMUL;
				end
				S_QMUL:  state_q <= S_QWAIT;
				S_QWAIT: state_q <= S_VINIT;
				S_VINIT: state_q <= S_VRUN;
				S_VRUN: if (stat.cordic_last) state_q <= S_HMUL;
				S_HMUL:  state_q <= S_HWAIT;
				S_HWAIT: state_q <= S_FIN;
				S_FIN: if (!stat.out_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/gps_heading_from_fixes.sv @@
// channel  role    modport  word
// fix      input   sink     fix_valid, fix_lat, fix_lon, fix_speed
// head     output  source   heading_cdeg, heading_reliable
// cfg      config  sink     index 0 min_speed, index 1 min_move
// a gated-off fix goes straight to the output word; any other fix makes
// four passes through the one shared cordic unit
// reset clears control, previous fix, held heading; thresholds to defaults
// the result sits in an output register; a new fix is taken while it waits,
// and a stalled head channel holds the block only at the end of the next fix
module gps_heading_from_fixes #(
	parameter int CORDIC_STEPS = gpshd_pkg::CORDIC_STEPS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	fix_if.sink    fix,
	head_if.source head,
	cfg_if.sink    cfg
);
	import gpshd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gpshd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fix.valid),
		.in_ready (fix.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	gpshd_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.in_fix_valid (fix.fix_valid),
		.in_lat       (fix.fix_lat),
		.in_lon       (fix.fix_lon),
		.in_speed     (fix.fix_speed),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

@@ verif/gps_heading_from_fixes_sb.sv @@
`timescale 1ns / 100ps

class heading_scoreboard;
	bit [16:0] min_speed;
	bit [19:0] min_move;
	longint prev_lat;
	longint prev_lon;
	bit prev_valid;
	bit [15:0] held_heading;
	bit [15:0] exp_heading[64];
	bit exp_rel[64];
	int exp_wr;
	int exp_rd;
	int mismatches;
	int checked;
	int reliable_seen;

	function void reset_state();
		min_speed = gpshd_pkg::MIN_SPEED_RST;
		min_move = gpshd_pkg::MIN_MOVE_RST;
		prev_lat = 0;
		prev_lon = 0;
		prev_valid = 0;
		held_heading = 0;
		exp_wr = 0;
		exp_rd = 0;
		mismatches = 0;
		checked = 0;
		reliable_seen = 0;
	endfunction

	function int pending();
		return exp_wr - exp_rd;
	endfunction

	function void write_reg(bit [7:0] idx, bit [31:0] data);
		if (idx == gpshd_pkg::REG_MIN_SPEED)
			min_speed = data[16:0];
		else if (idx == gpshd_pkg::REG_MIN_MOVE)
			min_move = data[19:0];
	endfunction

	// arithmetic shift right, rounding toward minus infinity
	function longint sar(longint v, int s);
		return v >>> s;
	endfunction

	function bit [31:0] deg7_to_bam(longint d);
		longint unsigned m;
		bit [31:0] r;
		m = (d < 0) ? -d : d;
		r = (m * 64'd1281023894 + (64'd1 << 29)) >> 30;
		return (d < 0) ? -r : r;
	endfunction

	function void sin_cos(bit [31:0] a, output longint s, output longint c);
		bit [31:0] sum;
		bit flip;
		longint x, y, z, nx, ny;
		sum = a + 32'h40000000;
		flip = sum[31];
		x = 652032874;
		y = 0;
		if (flip)
			a = a - 32'h80000000;
		z = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
		for (int i = 0; i < gpshd_pkg::CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = x - sar(y, i); ny = y + sar(x, i);
				z -= gpshd_pkg::atan_lut(5'(i));
			end else begin
				nx = x + sar(y, i); ny = y - sar(x, i);
				z += gpshd_pkg::atan_lut(5'(i));
			end
			x = nx; y = ny;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function bit [31:0] atan2_bam(longint y, longint x);
		longint z, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd2147483648;
		end
		for (int i = 0; i < gpshd_pkg::CORDIC_STEPS_DEF; i++) begin
			if (y == 0)
				break;
			if (y > 0) begin
				nx = x + sar(y, i); ny = y - sar(x, i);
				z += gpshd_pkg::atan_lut(5'(i));
			end else begin
				nx = x - sar(y, i); ny = y + sar(x, i);
				z -= gpshd_pkg::atan_lut(5'(i));
			end
			x = nx; y = ny;
		end
		return z[31:0];
	endfunction

	function bit [15:0] bearing(longint lat1, longint lon1, longint lat2, longint lon2);
		longint s1, c1, s2, c2, sd, cd, y, x, t;
		bit [31:0] dlon, b;
		longint unsigned p;
		dlon = deg7_to_bam(lon2) - deg7_to_bam(lon1);
		sin_cos(deg7_to_bam(lat1), s1, c1);
		sin_cos(deg7_to_bam(lat2), s2, c2);
		sin_cos(dlon, sd, cd);
		y = sar(sd * c2, 30);
		t = sar(s1 * c2, 30);
		x = sar(c1 * s2, 30) - sar(t * cd, 30);
		b = atan2_bam(y, x);
		p = (64'(b) * 64'd36000) >> 32;
		return p[15:0];
	endfunction

	function void note_fix(bit v, bit [30:0] lat_w, bit [31:0] lon_w, bit [16:0] spd);
		longint lat, lon, dl, dn, mv;
		bit rel;
		lat = longint'($signed(lat_w));
		lon = longint'($signed(lon_w));
		rel = 0;
		if (v && prev_valid && spd >= min_speed) begin
			dl = lat - prev_lat;
			dn = lon - prev_lon;
			mv = (dl < 0 ? -dl : dl) + (dn < 0 ? -dn : dn);
			if (mv >= longint'(min_move)) begin
				held_heading = bearing(prev_lat, prev_lon, lat, lon);
				rel = 1;
			end
		end
		prev_lat = lat;
		prev_lon = lon;
		prev_valid = v;
		exp_heading[exp_wr % 64] = held_heading;
		exp_rel[exp_wr % 64] = rel;
		exp_wr++;
	endfunction

	function void check_heading(bit [15:0] h, bit r);
		bit [15:0] eh;
		bit er;
		if (pending() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected heading word: %0d rel %0b", h, r);
			return;
		end
		eh = exp_heading[exp_rd % 64];
		er = exp_rel[exp_rd % 64];
		exp_rd++;
		checked++;
		if (r)
			reliable_seen++;
		if (eh !== h || er !== r) begin
			mismatches++;
			if (mismatches <= 10)
				$display("heading mismatch #%0d: exp %0d rel %0b, got %0d rel %0b",
					checked, eh, er, h, r);
		end
	endfunction
endclass

@@ verif/gps_heading_from_fixes_tb.sv @@
`timescale 1ns / 100ps

module gps_heading_from_fixes_tb;
	import gpshd_pkg::*;

	logic clk;
	logic arst_n;
	fix_if fix();
	head_if head();
	cfg_if cfg();
	heading_scoreboard sb;
	longint cycles;
	int fixes_sent;
	bit fill_done;

	gps_heading_from_fixes dut (
		.clk(clk), .arst_n(arst_n), .fix(fix.sink), .head(head.source), .cfg(cfg.sink)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("[gps_heading_from_fixes] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && head.valid && head.ready)
			sb.check_heading(head.heading_cdeg, head.heading_reliable);
	end

	// sink side: random stall before each word, sometimes none
	initial begin
		int gap;
		head.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (fill_done) gap = 0;
			if (gap > 0) begin
				head.ready <= 0;
				repeat (gap) @(negedge clk);
			end
			head.ready <= 1;
			do @(posedge clk); while (!(head.valid && head.ready));
		end
	end

	task automatic write_reg(bit [7:0] idx, bit [31:0] data);
		@(negedge clk);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send_fix(bit v, bit [30:0] lat, bit [31:0] lon, bit [16:0] spd, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			fix.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		fix.valid <= 1; fix.fix_valid <= v; fix.fix_lat <= lat; fix.fix_lon <= lon;
		fix.fix_speed <= spd;
		do @(posedge clk); while (!fix.ready);
		sb.note_fix(v, lat, lon, spd);
		fixes_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		fix.valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic bit [30:0] rnd_lat();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 31'($urandom);
		if (r == 1) return ($urandom_range(0, 1)) ? 31'sd900000000 : -31'sd900000000;
		return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
	endfunction

	function automatic bit [31:0] rnd_lon();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom;
		if (r == 1) return ($urandom_range(0, 1)) ? 32'sd1800000000 : -32'sd1800000000;
		return 32'($signed($urandom_range(0, 3600000000)) - 64'sd1800000000);
	endfunction

	initial begin
		bit [30:0] lat;
		bit [31:0] lon;
		bit [16:0] spd;
		int step, burst_phase;
		fix.valid = 0; fix.fix_valid = 0; fix.fix_lat = 0; fix.fix_lon = 0;
		fix.fix_speed = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		sb = new();
		sb.reset_state();
		fixes_sent = 0;
		fill_done = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, coincident points, due north, antimeridian, invalid, slow
		send_fix(1, 0, 0, 1000, 0);
		send_fix(1, 0, 0, 1000, 0);
		send_fix(1, 1000, 0, 1000, 0);
		send_fix(1, 31'sd900000000, 32'sd1800000000, 17'd100000, 0);
		send_fix(1, -31'sd900000000, -32'sd1800000000, 17'd100000, 1);
		send_fix(1, 31'h3FFFFFFF, 32'h7FFFFFFF, 17'h1FFFF, 0);
		send_fix(1, 31'h40000000, 32'h80000000, 17'h1FFFF, 0);
		send_fix(1, 0, 32'sd1799999000, 500, 0);
		send_fix(1, 0, -32'sd1799999000, 500, 0);
		send_fix(0, 5000, 5000, 500, 0);
		send_fix(1, 9000, 9000, 500, 0);
		send_fix(1, 19000, 19000, 199, 0);
		send_fix(1, 19010, 19030, 200, 0);
		send_fix(1, 19010, 19079, 200, 0);
		send_fix(1, 19010, 19080, 200, 0);
		drain();

		write_reg(REG_MIN_SPEED, 0);
		write_reg(REG_MIN_MOVE, 0);
		write_reg(8'd7, 32'hFFFFFFFF);
		send_fix(1, 500000000, 100, 0, 0);
		send_fix(1, 500000000, 100, 0, 0);
		send_fix(1, 500000000, 101, 0, 0);
		drain();
		write_reg(REG_MIN_SPEED, 32'hFFFFFFFF);
		write_reg(REG_MIN_MOVE, 32'hFFFFFFFF);
		send_fix(1, 0, 0, 17'h1FFFF, 0);
		send_fix(1, 31'sd900000000, 0, 17'h1FFFF, 0);
		send_fix(1, 0, 32'sd1000000, 17'h1FFFE, 0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin write_reg(REG_MIN_SPEED, 200); write_reg(REG_MIN_MOVE, 50); end
				1: begin write_reg(REG_MIN_SPEED, 100000); write_reg(REG_MIN_MOVE, 1000000); end
				2: begin write_reg(REG_MIN_SPEED, 0); write_reg(REG_MIN_MOVE, 0); end
				default: begin
					write_reg(REG_MIN_SPEED, $urandom_range(0, 5000));
					write_reg(REG_MIN_MOVE, $urandom_range(0, 20000));
				end
			endcase
			lat = rnd_lat();
			lon = rnd_lon();
			burst_phase = $urandom_range(0, 1);
			for (int k = 0; k < 405; k++) begin
				// mostly a track with small random steps, sometimes a jump
				if ($urandom_range(0, 9) == 0) begin
					lat = rnd_lat();
					lon = rnd_lon();
				end else begin
					step = (phase == 1) ? 2000000 : 30000;
					lat = lat + 31'($signed($urandom_range(0, 2 * step)) - step);
					lon = lon + 32'($signed($urandom_range(0, 2 * step)) - step);
				end
				spd = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
					17'($urandom_range(0, (phase == 1) ? 100000 : 3000));
				send_fix($urandom_range(0, 9) != 0, lat, lon, spd,
					burst_phase && k < 60);
			end
			drain();
		end

		fill_done = 1;
		drain();
		$display("fixes sent %0d, headings checked %0d, reliable %0d, mismatches %0d",
			fixes_sent, sb.checked, sb.reliable_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[gps_heading_from_fixes] OK");
		else
			$display("[gps_heading_from_fixes] ERROR");
		$finish;
	end
endmodule
